// ===== rtl/cbt_pkg.sv =====
// Shared types and constants of the cubic B-spline tessellator.
// No dependencies; imported by every module under rtl/.
package cbt_pkg;

	localparam int LOD_W      = 6;               // detail register width
	localparam int LOD_CODES  = 1 << LOD_W;
	localparam int T_W        = 17;              // t in unsigned Q1.16, t = 1 exact
	localparam int T_FRAC     = 16;
	localparam logic [T_W-1:0] T_ONE = T_W'(1 << T_FRAC);
	localparam logic [LOD_W-1:0] LOD_RESET = LOD_W'(15);
	localparam int STAGES     = 8;               // lane pipeline depth

	// one sample slot handed from the sequencer to the lanes
	typedef struct packed {
		logic           valid;
		logic           last;
		logic [T_W-1:0] t;
	} issue_t;

	// control riding alongside the lane data
	typedef struct packed {
		logic valid;
		logic last;
	} ctrl_t;

endpackage

// ===== rtl/cbt_seq.sv =====
// Point window, segment sequencer and incremental t generator.
// Depends on cbt_pkg.
module cbt_seq #(
	parameter int COORD_WIDTH = 16,
	parameter int MAX_DETAIL  = 63
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic                          s_fire,
	input  logic signed [COORD_WIDTH-1:0] point_x,
	input  logic signed [COORD_WIDTH-1:0] point_y,
	input  logic                          curve_start,
	input  logic [cbt_pkg::LOD_W-1:0]     lod,
	output logic                          ready,
	output logic                          load,
	output cbt_pkg::issue_t               issue,
	output logic signed [COORD_WIDTH-1:0] win_x [3],
	output logic signed [COORD_WIDTH-1:0] win_y [3]
);
	import cbt_pkg::*;

	// step of T per sample is 65536/L as quotient plus remainder over 2L
	logic [T_W-1:0]   q_tab [LOD_CODES];
	logic [LOD_W:0]   r_tab [LOD_CODES];

	for (genvar g = 0; g < LOD_CODES; g++) begin : g_tab
		localparam int unsigned DIV = (g == 0) ? 1 : g;
		localparam int unsigned QV  = 65536 / DIV;
		localparam int unsigned RV  = 2 * (65536 % DIV);
		assign q_tab[g] = T_W'(QV);
		assign r_tab[g] = (LOD_W + 1)'(RV);
	end

	logic signed [COORD_WIDTH-1:0] win_x_q [3];
	logic signed [COORD_WIDTH-1:0] win_y_q [3];
	logic [1:0]       seen_q;
	logic             busy_q;
	logic [LOD_W-1:0] i_q;
	logic [LOD_W-1:0] lod_q;
	logic [T_W-1:0]   t_q;
	logic [LOD_W:0]   rem_q;

	logic [LOD_W-1:0] lod_eff;
	logic             last;
	logic             emit;
	logic [LOD_W+1:0] rsum;
	logic [LOD_W+1:0] two_l;
	logic             wrap;

	always_comb begin
		if (lod == '0)
			lod_eff = LOD_W'(1);
		else if (lod > LOD_W'(MAX_DETAIL))
			lod_eff = LOD_W'(MAX_DETAIL);
		else
			lod_eff = lod;
	end

	assign last  = (i_q == lod_q);
	assign emit  = (seen_q == 2'd3) && !curve_start;
	assign load  = s_fire && emit;
	assign ready = !busy_q || (last && adv);

	assign rsum  = {1'b0, rem_q} + {1'b0, r_tab[lod_q]};
	assign two_l = {1'b0, lod_q, 1'b0};
	assign wrap  = (rsum >= two_l);

	assign issue.valid = busy_q;
	assign issue.last  = last;
	assign issue.t     = t_q;

	assign win_x = win_x_q;
	assign win_y = win_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				win_x_q[k] <= '0;
				win_y_q[k] <= '0;
			end
			seen_q <= '0;
			busy_q <= 1'b0;
			i_q    <= '0;
			lod_q  <= LOD_W'(1);
			t_q    <= '0;
			rem_q  <= '0;
		end else begin
			if (s_fire) begin
				if (curve_start) begin
					win_x_q[0] <= '0;
					win_x_q[1] <= '0;
					win_y_q[0] <= '0;
					win_y_q[1] <= '0;
					seen_q     <= 2'd1;
				end else begin
					win_x_q[0] <= win_x_q[1];
					win_x_q[1] <= win_x_q[2];
					win_y_q[0] <= win_y_q[1];
					win_y_q[1] <= win_y_q[2];
					if (seen_q != 2'd3)
						seen_q <= seen_q + 2'd1;
				end
				win_x_q[2] <= point_x;
				win_y_q[2] <= point_y;
			end

			if (load) begin
				busy_q <= 1'b1;
				i_q    <= '0;
				t_q    <= '0;
				rem_q  <= {1'b0, lod_eff};
				lod_q  <= lod_eff;
			end else if (adv && busy_q) begin
				if (last) begin
					busy_q <= 1'b0;
				end else begin
					i_q <= i_q + LOD_W'(1);
					if (wrap) begin
						rem_q <= (LOD_W + 1)'(rsum - two_l);
						t_q   <= t_q + q_tab[lod_q] + T_W'(1);
					end else begin
						rem_q <= rsum[LOD_W:0];
						t_q   <= t_q + q_tab[lod_q];
					end
				end
			end
		end
	end

endmodule

// ===== rtl/cbt_lane.sv =====
// One coordinate axis: segment coefficients and the Horner / divide-by-six
// pipeline that turns a t value into a rounded, saturated sample. Uses cbt_pkg.
module cbt_lane #(
	parameter int COORD_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          adv,
	input  logic                          load,
	input  logic signed [COORD_WIDTH-1:0] p1,
	input  logic signed [COORD_WIDTH-1:0] p2,
	input  logic signed [COORD_WIDTH-1:0] p3,
	input  logic signed [COORD_WIDTH-1:0] p4,
	input  logic [cbt_pkg::T_W-1:0]       t,
	output logic signed [COORD_WIDTH-1:0] sample
);
	import cbt_pkg::*;

	localparam int CW = COORD_WIDTH;
	localparam int RW = CW + 6;            // Horner accumulator
	localparam int PW = RW + T_W + 1;      // product with signed t
	localparam int UW = CW + 8;            // biased, non-negative numerator
	localparam int QW = UW - 2;            // quotient of u / 6
	localparam int SH = UW + 3;            // reciprocal scale
	localparam int MW = UW + 1;
	localparam int VW = CW + 7;
	localparam logic [MW-1:0] RECIP = MW'((64'd1 << SH) / 64'd6);
	localparam logic [UW-1:0] BIAS  = UW'(64'd3 + (64'd6 << (CW + 5)));
	localparam logic [VW-1:0] OFS   = VW'(64'd1 << (CW + 5));
	localparam logic signed [VW-1:0] SAT_HI = VW'((64'd1 << (CW - 1)) - 64'd1);
	localparam logic signed [VW-1:0] SAT_LO = -SAT_HI - VW'(1);
	localparam logic [PW-1:0] HALF  = PW'(1 << (T_FRAC - 1));

	function automatic logic signed [RW-1:0] rnd(input logic signed [PW-1:0] p);
		logic signed [PW-1:0] s;
		s = p + $signed(HALF);
		return RW'(s >>> T_FRAC);
	endfunction

	logic signed [RW-1:0] e1, e2, e3, e4, e1x3, e2x3, e3x3;
	logic signed [RW-1:0] a_q, b_q, c_q, d_q;

	assign e1   = {{(RW-CW){p1[CW-1]}}, p1};
	assign e2   = {{(RW-CW){p2[CW-1]}}, p2};
	assign e3   = {{(RW-CW){p3[CW-1]}}, p3};
	assign e4   = {{(RW-CW){p4[CW-1]}}, p4};
	assign e1x3 = (e1 <<< 1) + e1;
	assign e2x3 = (e2 <<< 1) + e2;
	assign e3x3 = (e3 <<< 1) + e3;

	always_ff @(posedge clk) begin
		if (load) begin
			a_q <= e2x3 - e1 - e3x3 + e4;
			b_q <= e1x3 - (e2x3 <<< 1) + e3x3;
			c_q <= e3x3 - e1x3;
			d_q <= e1 + (e2 <<< 2) + e3;
		end
	end

	logic signed [PW-1:0] prod_s1, prod_s3, prod_s5;
	logic signed [RW-1:0] b_s1, c_s1, d_s1, r_s2, c_s2, d_s2, c_s3, d_s3;
	logic signed [RW-1:0] r_s4, d_s4, d_s5;
	logic [T_W-1:0]       t_s1, t_s2, t_s3, t_s4;
	logic [UW-1:0]        u_s6, u_s7;
	logic [UW+MW-1:0]     prod_s7;
	logic signed [CW-1:0] sample_s8;

	logic signed [RW-1:0] r3;
	logic [UW-1:0]        r3x;
	logic [QW-1:0]        q0;
	logic [UW-1:0]        rem;
	logic [QW-1:0]        q;
	logic signed [VW-1:0] v;

	assign r3  = rnd(prod_s5) + d_s5;
	assign r3x = {{(UW-RW){r3[RW-1]}}, r3};

	// u / 6 by reciprocal, low by at most one, fixed with one compare
	assign q0  = prod_s7[SH+QW-1:SH];
	assign rem = u_s7 - (UW'({q0, 2'b00}) + UW'({q0, 1'b0}));
	assign q   = (rem >= UW'(6)) ? q0 + QW'(1) : q0;
	assign v   = $signed(VW'(q)) - $signed(OFS);

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1 <= a_q * $signed({1'b0, t});
			b_s1 <= b_q;
			c_s1 <= c_q;
			d_s1 <= d_q;
			t_s1 <= t;

			r_s2 <= rnd(prod_s1) + b_s1;
			c_s2 <= c_s1;
			d_s2 <= d_s1;
			t_s2 <= t_s1;

			prod_s3 <= r_s2 * $signed({1'b0, t_s2});
			c_s3 <= c_s2;
			d_s3 <= d_s2;
			t_s3 <= t_s2;

			r_s4 <= rnd(prod_s3) + c_s3;
			d_s4 <= d_s3;
			t_s4 <= t_s3;

			prod_s5 <= r_s4 * $signed({1'b0, t_s4});
			d_s5 <= d_s4;

			u_s6 <= r3x + BIAS;

			prod_s7 <= u_s6 * RECIP;
			u_s7    <= u_s6;

			if (v > SAT_HI)
				sample_s8 <= SAT_HI[CW-1:0];
			else if (v < SAT_LO)
				sample_s8 <= SAT_LO[CW-1:0];
			else
				sample_s8 <= v[CW-1:0];
		end
	end

	assign sample = sample_s8;

endmodule

// ===== rtl/cubic_bspline_tessellator.sv =====
// Uniform cubic B-spline tessellator. Control points (x, y in signed Q2.13)
// arrive one per beat; from the fourth point of a curve on, each point closes
// a segment over the last four points and the block emits L+1 samples of it
// at t = i/L (L is level_of_detail clamped to 1..MAX_DETAIL), one beat per
// cycle unless the output stalls, the last one flagged on tlast. A point
// with curve_start set in tuser empties the window first. The sequencer
// issues a segment's t values one per unstalled cycle, holding s_tready low
// till the last, and results pass the x and y lanes. Output stalls freeze
// the whole pipeline. level_of_detail resets to 15; the user must write it
// on the cfg channel (always ready) while the block is idle; not enforced.
// Depends on cbt_pkg, cbt_seq and cbt_lane.
module cubic_bspline_tessellator #(
	parameter int COORD_WIDTH = 16,
	parameter int MAX_DETAIL  = 63
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    s_tvalid,
	output logic                                    s_tready,
	input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]      s_tdata,  // point_x, point_y
	input  logic [0:0]                              s_tuser,  // curve_start
	output logic                                    m_tvalid,
	input  logic                                    m_tready,
	output logic [((2*COORD_WIDTH+7)/8)*8-1:0]      m_tdata,  // sample_x, sample_y
	output logic                                    m_tlast,
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [cbt_pkg::LOD_W-1:0]               cfg_data  // level_of_detail
);
	import cbt_pkg::*;

	localparam int CW = COORD_WIDTH;
	localparam int DW = ((2 * CW + 7) / 8) * 8;

	logic [LOD_W-1:0] lod_q;
	logic             s_fire;
	logic             adv;
	logic             load;
	issue_t           issue;
	ctrl_t            ctrl_s [STAGES];
	logic signed [CW-1:0] point_x, point_y, sample_x, sample_y;
	logic signed [CW-1:0] win_x [3];
	logic signed [CW-1:0] win_y [3];

	assign cfg_ready = 1'b1;
	assign point_x   = s_tdata[CW-1:0];
	assign point_y   = s_tdata[2*CW-1:CW];
	assign s_fire    = s_tvalid && s_tready;
	assign adv       = !ctrl_s[STAGES-1].valid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			lod_q <= LOD_RESET;
		else if (cfg_valid && cfg_ready)
			lod_q <= cfg_data;
	end

	cbt_seq #(
		.COORD_WIDTH (CW),
		.MAX_DETAIL  (MAX_DETAIL)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.s_fire      (s_fire),
		.point_x     (point_x),
		.point_y     (point_y),
		.curve_start (s_tuser[0]),
		.lod         (lod_q),
		.ready       (s_tready),
		.load        (load),
		.issue       (issue),
		.win_x       (win_x),
		.win_y       (win_y)
	);

	cbt_lane #(.COORD_WIDTH(CW)) u_lane_x (
		.clk    (clk),
		.adv    (adv),
		.load   (load),
		.p1     (win_x[0]),
		.p2     (win_x[1]),
		.p3     (win_x[2]),
		.p4     (point_x),
		.t      (issue.t),
		.sample (sample_x)
	);

	cbt_lane #(.COORD_WIDTH(CW)) u_lane_y (
		.clk    (clk),
		.adv    (adv),
		.load   (load),
		.p1     (win_y[0]),
		.p2     (win_y[1]),
		.p3     (win_y[2]),
		.p4     (point_y),
		.t      (issue.t),
		.sample (sample_y)
	);

	// control pipe matching the lane depth; its last stage is the output beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < STAGES; k++)
				ctrl_s[k] <= '0;
		end else if (adv) begin
			ctrl_s[0].valid <= issue.valid;
			ctrl_s[0].last  <= issue.last;
			for (int k = 1; k < STAGES; k++)
				ctrl_s[k] <= ctrl_s[k-1];
		end
	end

	assign m_tvalid = ctrl_s[STAGES-1].valid;
	assign m_tlast  = ctrl_s[STAGES-1].last;
	assign m_tdata  = DW'({sample_y, sample_x});

	a_load_issues: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> issue.valid)
		else $error("segment load did not start issuing");

	a_last_t_one: assert property (@(posedge clk) disable iff (!arst_n)
		issue.valid && issue.last |-> issue.t == T_ONE)
		else $error("final sample of segment not at t = 1");

	a_mid_t_below: assert property (@(posedge clk) disable iff (!arst_n)
		issue.valid && !issue.last |-> issue.t < T_ONE)
		else $error("t reached one before final sample");

	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		issue.valid && !issue.last |-> !s_tready)
		else $error("input ready while segment in progress");

endmodule
